/* rtl/mrfb_pkg.sv */
// ----------------------------------------------------------------------------
// mrfb_pkg
// types and constants shared by the request frame builder modules
// ----------------------------------------------------------------------------
package mrfb_pkg;

  localparam int FRAME_LEN = 8;
  localparam int HDR_LEN   = 6;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_COUNT     = 1'b1;

  localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'h11;
  localparam logic [15:0] READ_COUNT_RST     = 16'h0050;

  // request selector codes
  localparam logic [1:0] FUNC_READ_INPUT   = 2'd0;
  localparam logic [1:0] FUNC_READ_HOLDING = 2'd1;
  localparam logic [1:0] FUNC_WRITE_SINGLE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED       = 2'd3;

  // function codes on the wire
  localparam logic [7:0] FC_READ_INPUT   = 8'h04;
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  reg_addr;
    logic [15:0] write_value;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [15:0] read_count;
  } cfg_t;

  // frame bytes 0..5, element k is frame byte k
  typedef logic [HDR_LEN-1:0][7:0] hdr_t;

endpackage

/* rtl/mrfb_front.sv */
// ----------------------------------------------------------------------------
// mrfb_front
// accepts requests, drops the unused selector and assembles the frame header
// ----------------------------------------------------------------------------
module mrfb_front
  import mrfb_pkg::*;
(
  input  req_t in_data,
  input  logic in_push,
  output logic in_full,
  input  cfg_t cfg,
  output logic q_push,
  output hdr_t q_hdr,
  input  logic q_full
);

  logic [7:0] fcode;

  assign in_full = q_full;
  // unused selector is taken and produces nothing
  assign q_push  = in_push && !q_full && (in_data.func != FUNC_UNUSED);

  always_comb begin
    case (in_data.func)
      FUNC_READ_INPUT:   fcode = FC_READ_INPUT;
      FUNC_READ_HOLDING: fcode = FC_READ_HOLDING;
      FUNC_WRITE_SINGLE: fcode = FC_WRITE_SINGLE;
      default:           fcode = FC_READ_INPUT;
    endcase
  end

  always_comb begin
    q_hdr[0] = cfg.device_address;
    q_hdr[1] = fcode;
    q_hdr[2] = 8'h00;
    if (in_data.func == FUNC_WRITE_SINGLE) begin
      q_hdr[3] = in_data.reg_addr;
      q_hdr[4] = in_data.write_value[15:8];
      q_hdr[5] = in_data.write_value[7:0];
    end else begin
      q_hdr[3] = 8'h00;
      q_hdr[4] = cfg.read_count[15:8];
      q_hdr[5] = cfg.read_count[7:0];
    end
  end

endmodule

/* rtl/mrfb_queue.sv */
// ----------------------------------------------------------------------------
// mrfb_queue
// short queue of frame headers between front and back
// ----------------------------------------------------------------------------
module mrfb_queue
  import mrfb_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  hdr_t wr_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output hdr_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  hdr_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/mrfb_back.sv */
// ----------------------------------------------------------------------------
// mrfb_back
// sends the head frame one byte a cycle unless the output stalls, folding each header byte into the crc
// ----------------------------------------------------------------------------
module mrfb_back
  import mrfb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  hdr_t q_hdr,
  output logic q_pop,
  output logic out_empty,
  input  logic out_pop,
  output rsp_t out_data
);

  localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(HDR_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_data_r, out_data_nxt;
  logic             load;
  logic [7:0]       cur_byte;
  logic [15:0]      crc_base;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;
  assign load      = !q_empty && (!out_valid_r || out_pop);
  assign q_pop     = load && (idx_r == IDX_LAST);

  always_comb begin
    if (idx_r == IDX_CRC_HI) begin
      cur_byte = crc_r[15:8];
    end else if (idx_r == IDX_LAST) begin
      cur_byte = crc_r[7:0];
    end else begin
      cur_byte = q_hdr[idx_r];
    end
  end

  // first byte of a frame starts from the crc seed
  assign crc_base = (idx_r == '0) ? CRC_INIT : crc_r;

  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      idx_nxt                 = idx_r + IDX_W'(1);
      out_valid_nxt           = 1'b1;
      out_data_nxt.frame_byte = cur_byte;
      out_data_nxt.last_byte  = (idx_r == IDX_LAST);
      if (idx_r < IDX_CRC_HI) begin
        crc_nxt = crc_byte(crc_base, cur_byte);
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* rtl/modbus_request_frame_builder.sv */
// ----------------------------------------------------------------------------
// modbus_request_frame_builder
// a request taken into an idle block passes through the header queue and then the
// output register before its first byte can be popped
// throughput: one frame byte per cycle from the output register unless the output
// stalls; the header queue lets new requests in while a frame goes out
// reset: queue and output emptied, device address 0x11, read count 0x50
// ----------------------------------------------------------------------------
module modbus_request_frame_builder
  import mrfb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  req_t                 in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output rsp_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_full, q_pop, q_empty;
  hdr_t q_wr_hdr, q_rd_hdr;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS: cfg_nxt.device_address = cfg_data[7:0];
        REG_READ_COUNT:     cfg_nxt.read_count     = cfg_data[15:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= DEVICE_ADDRESS_RST;
      cfg_r.read_count     <= READ_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mrfb_front u_front (
    .in_data (in_data),
    .in_push (in_push),
    .in_full (in_full),
    .cfg     (cfg_r),
    .q_push  (q_push),
    .q_hdr   (q_wr_hdr),
    .q_full  (q_full)
  );

  mrfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_hdr),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_hdr)
  );

  mrfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_hdr     (q_rd_hdr),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // output comes up empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  // a frame never stalls in the middle: its next byte is always ready
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.last_byte) |=> !out_empty)
    else $error("gap inside a frame");

  // a request into an idle block shows its first byte once it has passed the header queue and the output register
  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_data.func != FUNC_UNUSED && q_empty && out_empty)
    |-> ##2 (!out_empty && out_data.frame_byte == $past(cfg_r.device_address, 2)))
    else $error("first frame byte missing or wrong");
`endif

endmodule

/* test/modbus_request_frame_builder_tb.sv */
// ----------------------------------------------------------------------------
// modbus_request_frame_builder_tb
// drives read, write and unused-selector requests through the frame builder in
// bursts while the byte side stalls on its own pattern; each read or write
// request taken is turned into its eight expected frame bytes (address, function,
// payload, crc-16) and every byte popped is checked in order. device address and
// read count are changed between phases, the extremes among them.
// ----------------------------------------------------------------------------
module modbus_request_frame_builder_tb
  import mrfb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT_REQS  = 200;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_REQS    = 100;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  req_t                 in_data = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  rsp_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  req_t        pending_reqs[$];
  rsp_t        frame_bytes_due[$];
  logic [7:0]  dev_addr_mirror;
  logic [15:0] read_count_mirror;
  int          errors = 0;
  int          reqs_taken = 0;
  int          cycles = 0;

  // sender burst state
  int burst_left = 0;
  int gap_left = 0;
  bit took;

  // receiver stall state
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  modbus_request_frame_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // builds the eight bytes of one request frame into the expected store
  task automatic predict_frame(input req_t rq);
    hdr_t        hdr;
    logic [15:0] crc;
    rsp_t        rb;
    if (rq.func == FUNC_UNUSED) return;
    hdr[0] = dev_addr_mirror;
    hdr[2] = 8'h00;
    if (rq.func == FUNC_WRITE_SINGLE) begin
      hdr[1] = FC_WRITE_SINGLE;
      hdr[3] = rq.reg_addr;
      hdr[4] = rq.write_value[15:8];
      hdr[5] = rq.write_value[7:0];
    end else begin
      hdr[1] = (rq.func == FUNC_READ_INPUT) ? FC_READ_INPUT : FC_READ_HOLDING;
      hdr[3] = 8'h00;
      hdr[4] = read_count_mirror[15:8];
      hdr[5] = read_count_mirror[7:0];
    end
    crc = CRC_INIT;
    for (int k = 0; k < HDR_LEN; k++) begin
      crc = crc ^ {8'h00, hdr[k]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    for (int k = 0; k < HDR_LEN; k++) begin
      rb.frame_byte = hdr[k];
      rb.last_byte  = 1'b0;
      frame_bytes_due.push_back(rb);
    end
    // crc goes out high byte first on this device
    rb.frame_byte = crc[15:8];
    rb.last_byte  = 1'b0;
    frame_bytes_due.push_back(rb);
    rb.frame_byte = crc[7:0];
    rb.last_byte  = 1'b1;
    frame_bytes_due.push_back(rb);
  endtask

  function automatic req_t rand_request();
    req_t rq;
    rq.func = ($urandom_range(0, 11) == 0) ? FUNC_UNUSED : 2'($urandom_range(0, 2));
    rq.reg_addr = 8'($urandom);
    case ($urandom_range(0, 5))
      0: rq.write_value = 16'h0000;
      1: rq.write_value = 16'hFFFF;
      2: rq.write_value = 16'h1 << $urandom_range(0, 15);
      default: rq.write_value = 16'($urandom);
    endcase
    return rq;
  endfunction

  function automatic req_t make_req(input logic [1:0] f, input logic [7:0] ra,
                                    input logic [15:0] wv);
    req_t rq;
    rq.func = f;
    rq.reg_addr = ra;
    rq.write_value = wv;
    return rq;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // waits until every item is taken and every byte has come out
  task automatic drain();
    while (pending_reqs.size() != 0 || in_push) @(negedge clk);
    while (frame_bytes_due.size() != 0) @(negedge clk);
    // an ignored request may still be in flight with nothing owed
    repeat (4) @(negedge clk);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      took = in_push && !in_full;
      if (took) void'(pending_reqs.pop_front());
      if (in_push && !took) begin
        // keep offering the same item
      end else if (gap_left > 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_push <= 1'b1;
        in_data <= pending_reqs[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // receiver: stall pattern that changes every so often, plus one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (!hold_done && reqs_taken >= HOLD_AT_REQS) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_pop <= 1'b1;
          1: out_pop <= ($urandom_range(0, 3) != 0);
          2: out_pop <= $urandom_range(0, 1);
          default: out_pop <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // predictor, register mirror and byte checker
  always @(posedge clk) begin
    rsp_t due;
    if (!rst_n) begin
      dev_addr_mirror   = DEVICE_ADDRESS_RST;
      read_count_mirror = READ_COUNT_RST;
    end else begin
      if (in_push && !in_full) begin
        predict_frame(in_data);
        reqs_taken++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DEVICE_ADDRESS: dev_addr_mirror = cfg_data[7:0];
          REG_READ_COUNT:     read_count_mirror = cfg_data;
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (frame_bytes_due.size() == 0) begin
          $error("unexpected frame byte %02h last %0b", out_data.frame_byte,
                 out_data.last_byte);
          errors++;
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_data.frame_byte !== due.frame_byte) begin
            $error("frame_byte: expected %02h, got %02h", due.frame_byte,
                   out_data.frame_byte);
            errors++;
          end
          if (out_data.last_byte !== due.last_byte) begin
            $error("last_byte: expected %0b, got %0b", due.last_byte,
                   out_data.last_byte);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [7:0]  addr_set [RANDOM_PHASES];
    logic [15:0] count_set [RANDOM_PHASES];
    addr_set[0] = 8'h00;  count_set[0] = 16'h0000;
    addr_set[1] = 8'hFF;  count_set[1] = 16'hFFFF;
    for (int p = 2; p < RANDOM_PHASES; p++) begin
      addr_set[p]  = 8'($urandom);
      count_set[p] = 16'($urandom);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, on the reset register values
    @(negedge clk);
    pending_reqs.push_back(make_req(FUNC_READ_INPUT, 8'h00, 16'h0000));
    pending_reqs.push_back(make_req(FUNC_READ_HOLDING, 8'h00, 16'h0000));
    pending_reqs.push_back(make_req(FUNC_READ_INPUT, 8'hFF, 16'hFFFF));
    pending_reqs.push_back(make_req(FUNC_WRITE_SINGLE, 8'h00, 16'h0000));
    pending_reqs.push_back(make_req(FUNC_WRITE_SINGLE, 8'hFF, 16'hFFFF));
    pending_reqs.push_back(make_req(FUNC_WRITE_SINGLE, 8'hA5, 16'h5AA5));
    pending_reqs.push_back(make_req(FUNC_WRITE_SINGLE, 8'h5A, 16'hA55A));
    // unused selector, alone and back to back
    pending_reqs.push_back(make_req(FUNC_UNUSED, 8'hFF, 16'hFFFF));
    pending_reqs.push_back(make_req(FUNC_READ_HOLDING, 8'h12, 16'h3456));
    pending_reqs.push_back(make_req(FUNC_UNUSED, 8'h00, 16'h0000));
    pending_reqs.push_back(make_req(FUNC_UNUSED, 8'h3C, 16'h8001));
    pending_reqs.push_back(make_req(FUNC_WRITE_SINGLE, 8'h01, 16'h8000));
    drain();

    write_reg(REG_DEVICE_ADDRESS, 16'h0000);
    write_reg(REG_READ_COUNT, 16'h0000);
    @(negedge clk);
    pending_reqs.push_back(make_req(FUNC_READ_INPUT, 8'h00, 16'h0000));
    pending_reqs.push_back(make_req(FUNC_READ_HOLDING, 8'hFF, 16'hFFFF));
    pending_reqs.push_back(make_req(FUNC_WRITE_SINGLE, 8'h80, 16'h0001));
    drain();

    write_reg(REG_DEVICE_ADDRESS, 16'h00FF);
    write_reg(REG_READ_COUNT, 16'hFFFF);
    @(negedge clk);
    pending_reqs.push_back(make_req(FUNC_READ_INPUT, 8'h00, 16'h0000));
    pending_reqs.push_back(make_req(FUNC_READ_HOLDING, 8'h00, 16'h0000));
    pending_reqs.push_back(make_req(FUNC_WRITE_SINGLE, 8'hFF, 16'hFFFF));
    drain();

    // random phases, one register setting each
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(REG_DEVICE_ADDRESS, {8'h00, addr_set[p]});
      write_reg(REG_READ_COUNT, count_set[p]);
      @(negedge clk);
      for (int i = 0; i < PHASE_REQS; i++) pending_reqs.push_back(rand_request());
      drain();
    end

    repeat (10) @(negedge clk);
    if (frame_bytes_due.size() != 0) begin
      $error("%0d frame bytes never came out", frame_bytes_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
